FILE: sv/cppb_pkg.sv
// Package for the chunk presence and pinning bitmap: widths, operation codes,
// register indexes and the controller state type. Depends on nothing.
package cppb_pkg;

  localparam int WORD_BITS    = 64;
  localparam int WORD_SHIFT   = 6;
  localparam int CHUNK_BYTES  = 1024;
  localparam int CHUNK_SHIFT  = 10;
  localparam int MAX_CHUNKS_DEF = 4096;

  localparam int KIND_W       = 3;
  localparam int OFF_W        = 32;
  localparam int CNT_W        = 32;
  localparam int FILE_BYTES_W = 23;
  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;

  // Derived range widths.
  localparam int END_W   = OFF_W + 1;
  localparam int FIRST_W = OFF_W - CHUNK_SHIFT;
  localparam int CEIL_W  = END_W - CHUNK_SHIFT + 1;
  localparam int QLAST_W = END_W - CHUNK_SHIFT;
  localparam int FBC_W   = FILE_BYTES_W - CHUNK_SHIFT + 1;

  // Operation codes carried by the kind field.
  localparam logic [KIND_W-1:0] KIND_QUERY = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MARK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PIN   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INVAL = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

  // Register index of file_bytes, taken from paddr[2].
  localparam logic REG_FILE_BYTES = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_CEIL,
    ST_CLIP,
    ST_RANGE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

FILE: sv/cppb_bitmap_ram.sv
// One bitmap store: a memory of 64-bit rows with one write port and one
// registered read port. Depends on cppb_pkg for the row width.
module cppb_bitmap_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [cppb_pkg::WORD_BITS-1:0] wdata,
  input  logic                           re,
  input  logic [AW-1:0]                  raddr,
  output logic [cppb_pkg::WORD_BITS-1:0] rdata
);
  import cppb_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/chunk_presence_pin_bitmap.sv
// Top level of the chunk presence and pinning bitmap: command sequencer,
// range arithmetic and the two bitmap stores. Depends on cppb_pkg and
// cppb_bitmap_ram.
//
//   Channel   Direction  Handshake                  Payload
//   command   in         start, busy                kind, byte_offset, byte_count
//   result    out        done (one-cycle strobe)    answer
//   config    in/out     psel, penable, pwrite, ... paddr, pwdata, prdata
//
// A command word is taken at a clock edge with start high and busy low.
// The states CEIL, CLIP and RANGE work out the chunk range, then the sequencer
// walks the rows of the maps that the range touches, one row per cycle
// through the read, modify and write-back of both memories. A command answered
// from the range alone goes from RANGE straight to DONE, and a clear passes
// through the clearing pass before DONE. busy falls in the cycle after done.
// Reset and every write to file_bytes start a clearing pass over all
// MAP_WORDS rows of both memories, during which busy is high. The receiver
// cannot stall the result word.
module chunk_presence_pin_bitmap #(
  parameter int MAX_CHUNKS = cppb_pkg::MAX_CHUNKS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [cppb_pkg::KIND_W-1:0]       kind,
  input  logic [cppb_pkg::OFF_W-1:0]        byte_offset,
  input  logic [cppb_pkg::CNT_W-1:0]        byte_count,
  output logic                              done,
  output logic                              answer,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cppb_pkg::PADDR_W-1:0]      paddr,
  input  logic [cppb_pkg::PDATA_W-1:0]      pwdata,
  output logic [cppb_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);
  import cppb_pkg::*;

  localparam int MAP_WORDS = (MAX_CHUNKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CI_W      = AW + WORD_SHIFT;
  localparam int CAP_W     = $clog2(MAX_CHUNKS + 1);

  // Configuration: file size and the figures derived from it.
  logic [FILE_BYTES_W-1:0] file_bytes;
  logic [FBC_W-1:0]        fb_chunks;
  logic [CAP_W-1:0]        cap;

  logic                    cfg_wr;
  logic [FILE_BYTES_W-1:0] cfg_fb;
  logic [FILE_BYTES_W:0]   cfg_csum;
  logic [FBC_W-1:0]        cfg_chunks;
  logic [FBC_W:0]          cfg_rsum;
  logic [FBC_W:0]          cfg_round;
  logic [CAP_W-1:0]        cfg_cap;

  state_t state, state_next;

  // Command registers and range arithmetic.
  logic [KIND_W-1:0]  kind_q;
  logic [FIRST_W-1:0] first_q;
  logic [END_W-1:0]   end_q;
  logic               cnt_zero_q;
  logic [CEIL_W-1:0]  ceil_end_q;
  logic [QLAST_W-1:0] qlast_q;
  logic               past_q;
  logic [CAP_W-1:0]   hi_q;

  logic [END_W:0]     ceil_sum;
  logic [END_W-1:0]   end_m1;
  logic [CEIL_W-1:0]  hi_sel;
  logic [CEIL_W-1:0]  hi_m1;
  logic               is_query;
  logic               is_marking;
  logic               q_early;
  logic               q_ans;
  logic               m_empty;
  logic               go_scan;
  logic               go_clear;
  logic [CI_W-1:0]    scan_lo;
  logic [CI_W-1:0]    scan_hi;

  // Row walk.
  logic [AW-1:0]         rd_w;
  logic [AW-1:0]         w_first;
  logic [AW-1:0]         w_last;
  logic [WORD_SHIFT-1:0] lo_bit;
  logic [WORD_SHIFT-1:0] hi_bit;
  logic                  issue_on;
  logic                  s1_valid;
  logic [AW-1:0]         s1_w;
  logic [AW-1:0]         clr_w;
  logic                  clr_item;
  logic                  ans;

  logic [WORD_BITS-1:0]  lo_mask;
  logic [WORD_BITS-1:0]  hi_mask;
  logic [WORD_BITS-1:0]  row_mask;

  // Memory ports.
  logic                  pres_we, pin_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [WORD_BITS-1:0]  pres_wdata, pin_wdata;
  logic [WORD_BITS-1:0]  pres_rdata, pin_rdata;

  //--------------------------------------------------------------------------
  // Configuration port. Only bit 2 of the address selects a register, so
  // every address with bit 2 low writes file_bytes; writes with bit 2 high are ignored.
  //--------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_FILE_BYTES);

  assign cfg_fb     = pwdata[FILE_BYTES_W-1:0];
  assign cfg_csum   = {1'b0, cfg_fb} + (FILE_BYTES_W + 1)'(CHUNK_BYTES - 1);
  assign cfg_chunks = cfg_csum[FILE_BYTES_W:CHUNK_SHIFT];
  assign cfg_rsum   = {1'b0, cfg_chunks} + (FBC_W + 1)'(WORD_BITS - 1);
  assign cfg_round  = {cfg_rsum[FBC_W:WORD_SHIFT], WORD_SHIFT'(0)};
  assign cfg_cap    = (32'(cfg_round) > 32'(MAX_CHUNKS)) ? CAP_W'(MAX_CHUNKS)
                                                          : CAP_W'(cfg_round);

  always_comb begin
    if (paddr[2] == REG_FILE_BYTES) begin
      prdata = PDATA_W'(file_bytes);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_bytes <= '0;
      fb_chunks  <= '0;
      cap        <= '0;
    end else if (cfg_wr) begin
      file_bytes <= cfg_fb;
      fb_chunks  <= cfg_chunks;
      cap        <= cfg_cap;
    end
  end

  //--------------------------------------------------------------------------
  // Range arithmetic for the CEIL and CLIP states and decisions made in RANGE.
  //--------------------------------------------------------------------------
  assign ceil_sum = {1'b0, end_q} + (END_W + 1)'(CHUNK_BYTES - 1);
  assign end_m1   = end_q - END_W'(1);
  assign hi_sel   = (past_q && (file_bytes != '0)) ? CEIL_W'(fb_chunks) : ceil_end_q;
  assign hi_m1    = CEIL_W'(hi_q) - CEIL_W'(1);

  assign is_query   = (kind_q == KIND_QUERY);
  assign is_marking = (kind_q == KIND_MARK) || (kind_q == KIND_PIN) ||
                      (kind_q == KIND_INVAL);
  // A query with no file, no length, or a last chunk beyond capacity needs
  // no walk over the maps.
  assign q_early  = (file_bytes == '0) || cnt_zero_q ||
                    (CEIL_W'(qlast_q) >= CEIL_W'(cap));
  assign q_ans    = (file_bytes != '0) && cnt_zero_q;
  assign m_empty  = !(CEIL_W'(first_q) < CEIL_W'(hi_q));
  assign go_scan  = (is_query && !q_early) || (is_marking && !m_empty);
  assign go_clear = (kind_q == KIND_CLEAR);
  assign scan_lo  = first_q[CI_W-1:0];
  assign scan_hi  = is_query ? qlast_q[CI_W-1:0] : hi_m1[CI_W-1:0];

  // Bits of the current row that lie inside the chunk range.
  assign lo_mask  = (s1_w == w_first) ? ({WORD_BITS{1'b1}} << lo_bit) : {WORD_BITS{1'b1}};
  assign hi_mask  = (s1_w == w_last) ? ({WORD_BITS{1'b1}} >> (WORD_SHIFT'(WORD_BITS - 1) - hi_bit))
                                     : {WORD_BITS{1'b1}};
  assign row_mask = lo_mask & hi_mask;

  //--------------------------------------------------------------------------
  // Sequencer: next state.
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CEIL;
        end
      end
      ST_CLEAR: begin
        if (clr_w == AW'(MAP_WORDS - 1)) begin
          state_next = clr_item ? ST_DONE : ST_IDLE;
        end
      end
      ST_CEIL:  state_next = ST_CLIP;
      ST_CLIP:  state_next = ST_RANGE;
      ST_RANGE: begin
        if (go_scan) begin
          state_next = ST_SCAN;
        end else if (go_clear) begin
          state_next = ST_CLEAR;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SCAN: begin
        // The last row is being written back in this cycle.
        if (!issue_on && s1_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
    // A new file size empties both maps, which restarts the clearing pass.
    if (cfg_wr) begin
      state_next = ST_CLEAR;
    end
  end

  //--------------------------------------------------------------------------
  // Sequencer: outputs and memory control.
  //--------------------------------------------------------------------------
  always_comb begin
    busy       = 1'b1;
    done       = 1'b0;
    pres_we    = 1'b0;
    pin_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = s1_w;
    mem_raddr  = rd_w;
    pres_wdata = '0;
    pin_wdata  = '0;
    unique case (state)
      ST_IDLE:  busy = 1'b0;
      ST_CLEAR: begin
        pres_we   = 1'b1;
        pin_we    = 1'b1;
        mem_waddr = clr_w;
      end
      ST_SCAN: begin
        mem_re  = issue_on;
        pres_we = s1_valid && ((kind_q == KIND_MARK) || (kind_q == KIND_INVAL));
        pin_we  = s1_valid && (kind_q == KIND_PIN);
        if (kind_q == KIND_MARK) begin
          pres_wdata = pres_rdata | row_mask;
        end else begin
          // Invalidate spares pinned chunks.
          pres_wdata = pres_rdata & ~(row_mask & ~pin_rdata);
        end
        pin_wdata = pin_rdata | row_mask;
      end
      ST_DONE:  done = 1'b1;
      default:  ;
    endcase
  end

  assign answer = ans;

  //--------------------------------------------------------------------------
  // Datapath registers.
  //--------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      issue_on <= 1'b0;
      s1_valid <= 1'b0;
      clr_w    <= '0;
      clr_item <= 1'b0;
      ans      <= 1'b1;
    end else begin
      s1_valid <= (state == ST_SCAN) && issue_on;
      s1_w     <= rd_w;
      case (state)
        ST_IDLE: begin
          kind_q     <= kind;
          first_q    <= byte_offset[OFF_W-1:CHUNK_SHIFT];
          end_q      <= END_W'(byte_offset) + END_W'(byte_count);
          cnt_zero_q <= (byte_count == '0);
        end
        ST_CEIL: begin
          ceil_end_q <= ceil_sum[END_W:CHUNK_SHIFT];
          qlast_q    <= end_m1[END_W-1:CHUNK_SHIFT];
          past_q     <= (end_q > END_W'(file_bytes));
        end
        ST_CLIP: begin
          hi_q <= (hi_sel > CEIL_W'(cap)) ? cap : hi_sel[CAP_W-1:0];
        end
        ST_RANGE: begin
          ans      <= is_query ? (q_early ? q_ans : 1'b1) : 1'b1;
          rd_w     <= scan_lo[CI_W-1:WORD_SHIFT];
          w_first  <= scan_lo[CI_W-1:WORD_SHIFT];
          w_last   <= scan_hi[CI_W-1:WORD_SHIFT];
          lo_bit   <= scan_lo[WORD_SHIFT-1:0];
          hi_bit   <= scan_hi[WORD_SHIFT-1:0];
          issue_on <= go_scan;
          clr_w    <= '0;
          clr_item <= 1'b1;
        end
        ST_SCAN: begin
          // Row addresses only climb within a command, so a read never
          // meets a write-back to the same row.
          if (issue_on) begin
            rd_w <= rd_w + AW'(1);
            if (rd_w == w_last) begin
              issue_on <= 1'b0;
            end
          end
          if (s1_valid) begin
            if (is_query) begin
              ans <= ans & (&(pres_rdata | ~row_mask));
            end else if (kind_q == KIND_INVAL) begin
              ans <= ans & ~(|(pin_rdata & row_mask));
            end
          end
        end
        ST_CLEAR: begin
          clr_w <= clr_w + AW'(1);
        end
        default: ;
      endcase
      if (cfg_wr) begin
        clr_w    <= '0;
        clr_item <= 1'b0;
      end
    end
  end

  //--------------------------------------------------------------------------
  // Bitmap stores.
  //--------------------------------------------------------------------------
  cppb_bitmap_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_present (
    .clk   (clk),
    .we    (pres_we),
    .waddr (mem_waddr),
    .wdata (pres_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (pres_rdata)
  );

  cppb_bitmap_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_pinned (
    .clk   (clk),
    .we    (pin_we),
    .waddr (mem_waddr),
    .wdata (pin_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (pin_rdata)
  );

endmodule

FILE: sv/cppb_checker.sv
// Port-level checks for the chunk presence and pinning bitmap, bound to the
// top level. Depends on cppb_pkg for port widths.
module cppb_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic                         pready,
  input logic [cppb_pkg::PADDR_W-1:0] paddr
);
  import cppb_pkg::*;

  // A command word that is taken keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("command taken but busy low next cycle");

  // A result is only given while the block is still busy with its command.
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done strobe while idle");

  // The result strobe lasts a single cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // A write to file_bytes starts a clearing pass.
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready && (paddr[2] == REG_FILE_BYTES) |=> busy)
    else $error("no clearing pass after file size write");

  // Reset starts a clearing pass.
  a_rst_clear: assert property (@(posedge clk)
    rst |=> busy)
    else $error("no clearing pass after reset");

endmodule

bind chunk_presence_pin_bitmap cppb_checker u_cppb_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .done    (done),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .pready  (pready),
  .paddr   (paddr)
);
